// File: sv/mbet_pkg.sv
// Shared types, constants and the microcode program of the escape-time unit.
package mbet_pkg;

  localparam int FRAC_BITS = 22;
  localparam int WORD_W = 32;
  localparam int COUNT_W = 16;
  localparam int STEP_W = 3;

  localparam logic [WORD_W-1:0] ESCAPE_LIMIT = WORD_W'(4) << FRAC_BITS;
  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = COUNT_W'(100);

  // datapath operations
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_MXX  = 3'd2;
  localparam logic [2:0] OP_MYY  = 3'd3;
  localparam logic [2:0] OP_MXY  = 3'd4;
  localparam logic [2:0] OP_UPD  = 3'd5;
  localparam logic [2:0] OP_EMIT = 3'd6;

  // jump conditions
  localparam logic [1:0] COND_ALWAYS   = 2'd0;
  localparam logic [1:0] COND_START    = 2'd1;
  localparam logic [1:0] COND_GO       = 2'd2;
  localparam logic [1:0] COND_OUT_FREE = 2'd3;

  // program addresses
  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MXX  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MYY  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MXY  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_UPD  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EMIT = 3'd5;

  typedef struct packed {
    logic [2:0]        op;
    logic              gated;    // op runs only when the condition holds
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;   // taken when the condition holds
    logic              advance;  // otherwise step on (1) or hold (0)
  } uword_t;

  typedef struct packed {
    logic [2:0] op;
    logic       exec;
    logic       idle;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic go;
    logic out_free;
  } status_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      STEP_IDLE: w = '{op: OP_LOAD, gated: 1'b1, cond: COND_START,
                       target: STEP_MXX, advance: 1'b0};
      STEP_MXX:  w = '{op: OP_MXX, gated: 1'b0, cond: COND_ALWAYS,
                       target: STEP_MYY, advance: 1'b0};
      STEP_MYY:  w = '{op: OP_MYY, gated: 1'b0, cond: COND_ALWAYS,
                       target: STEP_MXY, advance: 1'b0};
      STEP_MXY:  w = '{op: OP_MXY, gated: 1'b0, cond: COND_ALWAYS,
                       target: STEP_UPD, advance: 1'b0};
      STEP_UPD:  w = '{op: OP_UPD, gated: 1'b0, cond: COND_GO,
                       target: STEP_MXX, advance: 1'b1};
      STEP_EMIT: w = '{op: OP_EMIT, gated: 1'b1, cond: COND_OUT_FREE,
                       target: STEP_IDLE, advance: 1'b0};
      default:   w = '{op: OP_NOP, gated: 1'b0, cond: COND_ALWAYS,
                       target: STEP_IDLE, advance: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// File: sv/mbet_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module mbet_seq (
  input  logic             clk,
  input  logic             rst,
  input  mbet_pkg::status_t status,
  output mbet_pkg::ctrl_t   ctrl
);

  logic [mbet_pkg::STEP_W-1:0] pc;
  logic [mbet_pkg::STEP_W-1:0] pc_next;
  mbet_pkg::uword_t            uw;
  logic                        cond_true;

  assign uw = mbet_pkg::ucode(pc);

  always_comb begin
    case (uw.cond)
      mbet_pkg::COND_ALWAYS:   cond_true = 1'b1;
      mbet_pkg::COND_START:    cond_true = status.start;
      mbet_pkg::COND_GO:       cond_true = status.go;
      mbet_pkg::COND_OUT_FREE: cond_true = status.out_free;
      default:                 cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      pc_next = uw.target;
    end else if (uw.advance) begin
      pc_next = pc + mbet_pkg::STEP_W'(1);
    end else begin
      pc_next = pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mbet_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.op   = uw.op;
  assign ctrl.exec = cond_true || !uw.gated;
  assign ctrl.idle = (pc == mbet_pkg::STEP_IDLE);

endmodule

// File: sv/mbet_datapath.sv
// Datapath: shared multiplier, z and c registers, counter, limit and output register.
module mbet_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  mbet_pkg::ctrl_t                     ctrl,
  input  logic signed [mbet_pkg::WORD_W-1:0]  point_re,
  input  logic signed [mbet_pkg::WORD_W-1:0]  point_im,
  input  logic                                cfg_write,
  input  logic [mbet_pkg::COUNT_W-1:0]        cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [mbet_pkg::COUNT_W-1:0]        iteration_count,
  output logic                                go,
  output logic                                out_free
);

  localparam int W = mbet_pkg::WORD_W;
  localparam int CW = mbet_pkg::COUNT_W;
  localparam int FB = mbet_pkg::FRAC_BITS;

  logic [W-1:0]        x, y, cx, cy, xx, yy, xy;
  logic [CW-1:0]       count;
  logic [CW-1:0]       max_iterations;
  logic [W-1:0]        mul_a, mul_b;
  logic signed [2*W-1:0] product;
  logic [W-1:0]        mul_q;
  logic [W-1:0]        mag;
  logic [CW:0]         count_inc;

  // one multiplier, operands picked by the current step
  assign mul_a = (ctrl.op == mbet_pkg::OP_MYY) ? y : x;
  assign mul_b = (ctrl.op == mbet_pkg::OP_MXX) ? x : y;
  assign product = $signed(mul_a) * $signed(mul_b);
  assign mul_q = product[FB+W-1:FB];

  assign mag = xx + yy;
  assign count_inc = {1'b0, count} + (CW+1)'(1);
  assign go = ($signed(mag) < $signed(mbet_pkg::ESCAPE_LIMIT))
           && (count_inc < {1'b0, max_iterations});
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      case (ctrl.op)
        mbet_pkg::OP_LOAD: begin
          x     <= point_re;
          y     <= point_im;
          cx    <= point_re;
          cy    <= point_im;
          count <= '0;
        end
        mbet_pkg::OP_MXX: xx <= mul_q;
        mbet_pkg::OP_MYY: yy <= mul_q;
        mbet_pkg::OP_MXY: xy <= mul_q;
        mbet_pkg::OP_UPD: begin
          x     <= xx - yy + cx;
          y     <= {xy[W-2:0], 1'b0} + cy;
          count <= count_inc[CW-1:0];
        end
        mbet_pkg::OP_EMIT: iteration_count <= count;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      max_iterations <= mbet_pkg::MAX_ITER_RESET;
    end else begin
      if (cfg_write) begin
        max_iterations <= cfg_data;
      end
      if (ctrl.exec && ctrl.op == mbet_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/mandelbrot_escape_time_q22_unit.sv
// Escape-time counter: z = z*z + c from z = c, counts passes until escape or limit.
// Each pass runs three products through the one shared multiplier plus one update
// step of the microcode program; an emit step then moves the count into the output
// register, waiting while that holds a stalled result. A new item waits until idle.
// The next item is taken while the previous result waits in the output register.
// Reset (rst, synchronous): sequencer to idle, output empty, max_iterations = 100.
module mandelbrot_escape_time_q22_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mbet_pkg::WORD_W-1:0]  point_re,
  input  logic signed [mbet_pkg::WORD_W-1:0]  point_im,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mbet_pkg::COUNT_W-1:0]        iteration_count,
  input  logic                                cfg_write,
  input  logic [mbet_pkg::COUNT_W-1:0]        cfg_data
);

  mbet_pkg::ctrl_t   ctrl;
  mbet_pkg::status_t status;
  logic              go;
  logic              out_free;

  assign status.start    = in_valid;
  assign status.go       = go;
  assign status.out_free = out_free;
  assign in_stall        = !ctrl.idle;

  mbet_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mbet_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .point_re        (point_re),
    .point_im        (point_im),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .iteration_count (iteration_count),
    .go              (go),
    .out_free        (out_free)
  );

endmodule

// File: sv/mbet_check.sv
// Port-level checks for the escape-time unit and the bind that attaches them.
module mbet_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [mbet_pkg::COUNT_W-1:0] iteration_count,
  input logic                         cfg_write,
  input logic [mbet_pkg::COUNT_W-1:0] cfg_data
);

  logic [mbet_pkg::COUNT_W-1:0] limit;

  // track the programmed limit
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= mbet_pkg::MAX_ITER_RESET;
    end else if (cfg_write) begin
      limit <= cfg_data;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while another is in flight");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> iteration_count != '0
      && (iteration_count <= limit || iteration_count == mbet_pkg::COUNT_W'(1)))
    else $error("iteration count outside 1..limit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(iteration_count))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("unit not empty after reset");

endmodule

bind mandelbrot_escape_time_q22_unit mbet_check u_mbet_check (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .iteration_count (iteration_count),
  .cfg_write       (cfg_write),
  .cfg_data        (cfg_data)
);
